FILE: hw/rtl/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

  // width of the scaled channel sum (real value times 120e6)
  localparam int unsigned ValW = 30;
  // sum at or above this gives full scale
  localparam int unsigned ClipVal = 120000000;
  // 255 / 120e6 = 17 / (2^9 * 15625)
  localparam int unsigned PreMul = 17;
  localparam int unsigned PreShift = 9;
  localparam int unsigned QuotW = 22;
  // ceil(2^36 / 15625), exact for every quotient input below 2^22
  localparam int unsigned RecipW = 23;
  localparam logic [RecipW-1:0] RecipM = 23'd4398047;
  localparam int unsigned RecipShift = 36;

  typedef enum logic [2:0] {
    SEC_RED_X   = 3'd0,
    SEC_X_GREEN = 3'd1,
    SEC_GREEN_X = 3'd2,
    SEC_X_BLUE  = 3'd3,
    SEC_BLUE_X  = 3'd4,
    SEC_RED_XB  = 3'd5
  } sector_e;

  typedef struct packed {
    logic ld_w;
    logic ld_q;
  } stage_ctl_t;

endpackage

FILE: hw/rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSL to RGB colour converter.
// Input stream (s_axis): one colour per transaction, hue in whole degrees,
// saturation and lightness in thousandths. Output stream (m_axis): one
// transaction per input with 8-bit red, green and blue, saturated to 0..255.
// Hue 360..511 lands in the last sector, as does 300..359.
// Pipeline: five register stages: hue/lightness decode, chroma multiply,
// component multiply, sum and pre-scale, reciprocal multiply and saturation.
// Throughput: one colour per clock while m_axis_tready is high; every stage
// holds its own valid bit.
// Stall: each stage takes new data when empty or when the stage after it
// moves, so bubbles close up while m_axis_tready is low and s_axis_tready
// stays high until all five stages are full. Nothing is dropped or repeated.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
// No configuration registers.
module hsl_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] hue_degrees, [18:9] saturation_milli, [28:19] lightness_milli, rest zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red_level, [15:8] green_level, [23:16] blue_level, rest zero
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned VW = h2r_pkg::ValW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3;
  h2r_pkg::stage_ctl_t lvl_ctl;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld1 = rdy1 && s_axis_tvalid;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign lvl_ctl.ld_w = rdy4 && v3_q;
  assign lvl_ctl.ld_q = rdy5 && v4_q;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---- stage 1: hue sector and position, lightness term ----
  logic [8:0]  hue;
  logic [9:0]  sat;
  logic [9:0]  lig;
  logic [8:0]  hue_base;
  logic [8:0]  hue_mod;
  logic [6:0]  hue_dist;
  logic [10:0] two_l;
  logic [10:0] l_dist;
  h2r_pkg::sector_e sec_d, sec1_q, sec2_q, sec3_q;
  logic signed [11:0] a_d, a1_q;
  logic [5:0]  f_d, f1_q, f2_q;
  logic [9:0]  s1_q;
  logic [9:0]  l1_q, l2_q;

  assign hue = s_axis_tdata[8:0];
  assign sat = s_axis_tdata[18:9];
  assign lig = s_axis_tdata[28:19];

  always_comb begin
    if (hue >= 9'd480)      hue_base = 9'd480;
    else if (hue >= 9'd360) hue_base = 9'd360;
    else if (hue >= 9'd240) hue_base = 9'd240;
    else if (hue >= 9'd120) hue_base = 9'd120;
    else                    hue_base = 9'd0;
    hue_mod  = hue - hue_base;
    hue_dist = (hue_mod >= 9'd60) ? 7'(hue_mod - 9'd60) : 7'(9'd60 - hue_mod);
    f_d      = 6'(7'd60 - hue_dist);

    if (hue < 9'd60)       sec_d = h2r_pkg::SEC_RED_X;
    else if (hue < 9'd120) sec_d = h2r_pkg::SEC_X_GREEN;
    else if (hue < 9'd180) sec_d = h2r_pkg::SEC_GREEN_X;
    else if (hue < 9'd240) sec_d = h2r_pkg::SEC_X_BLUE;
    else if (hue < 9'd300) sec_d = h2r_pkg::SEC_BLUE_X;
    else                   sec_d = h2r_pkg::SEC_RED_XB;

    two_l  = {lig, 1'b0};
    l_dist = (two_l >= 11'd1000) ? (two_l - 11'd1000) : (11'd1000 - two_l);
    a_d    = 12'sd1000 - signed'({1'b0, l_dist});
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      sec1_q <= sec_d;
      f1_q   <= f_d;
      a1_q   <= a_d;
      s1_q   <= sat;
      l1_q   <= lig;
    end
  end

  // ---- stage 2: chroma numerator cn = (1000 - |2l - 1000|) * s ----
  logic signed [22:0] cn_prod;
  logic signed [20:0] cn2_q;

  assign cn_prod = 23'(a1_q) * signed'(23'({1'b0, s1_q}));

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      cn2_q  <= cn_prod[20:0];
      sec2_q <= sec1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
    end
  end

  // ---- stage 3: scaled chroma, secondary and offset ----
  logic signed [VW-1:0] cn_ext;
  logic signed [VW-1:0] f2_ext;
  logic signed [VW-1:0] l_ext;
  logic signed [VW-1:0] cs_d, cs3_q;
  logic signed [VW-1:0] xs_d, xs3_q;
  logic signed [VW-1:0] ms_d, ms3_q;

  always_comb begin
    cn_ext = VW'(cn2_q);
    f2_ext = signed'(VW'({f2_q, 1'b0}));
    l_ext  = signed'(VW'(l2_q));
    cs_d   = cn_ext * signed'(VW'(120));
    xs_d   = cn_ext * f2_ext;
    ms_d   = l_ext * signed'(VW'(120000)) - cn_ext * signed'(VW'(60));
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      cs3_q  <= cs_d;
      xs3_q  <= xs_d;
      ms3_q  <= ms_d;
      sec3_q <= sec2_q;
    end
  end

  // ---- stage 4 input: place chroma and secondary on the channels ----
  logic signed [VW-1:0] r_comp, g_comp, b_comp;
  logic signed [VW-1:0] r_sum, g_sum, b_sum;

  always_comb begin
    r_comp = '0;
    g_comp = '0;
    b_comp = '0;
    case (sec3_q)
      h2r_pkg::SEC_RED_X: begin
        r_comp = cs3_q;
        g_comp = xs3_q;
      end
      h2r_pkg::SEC_X_GREEN: begin
        r_comp = xs3_q;
        g_comp = cs3_q;
      end
      h2r_pkg::SEC_GREEN_X: begin
        g_comp = cs3_q;
        b_comp = xs3_q;
      end
      h2r_pkg::SEC_X_BLUE: begin
        g_comp = xs3_q;
        b_comp = cs3_q;
      end
      h2r_pkg::SEC_BLUE_X: begin
        r_comp = xs3_q;
        b_comp = cs3_q;
      end
      default: begin
        r_comp = cs3_q;
        b_comp = xs3_q;
      end
    endcase
    r_sum = r_comp + ms3_q;
    g_sum = g_comp + ms3_q;
    b_sum = b_comp + ms3_q;
  end

  logic [7:0] red_level, green_level, blue_level;

  h2r_level u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lvl_ctl),
    .val_i   (r_sum),
    .level_o (red_level)
  );

  h2r_level u_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lvl_ctl),
    .val_i   (g_sum),
    .level_o (green_level)
  );

  h2r_level u_blue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lvl_ctl),
    .val_i   (b_sum),
    .level_o (blue_level)
  );

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {8'd0, blue_level, green_level, red_level};

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output is being taken");
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted transaction not held in the first stage");
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(a1_q) && $stable(f1_q)))
    else $error("first stage changed while stalled");
`endif

endmodule

FILE: hw/rtl/h2r_level.sv
`timescale 1ns / 1ps

// scaled sum to saturated 8-bit level, two register stages
module h2r_level (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  h2r_pkg::stage_ctl_t                 ctl_i,
  input  logic signed [h2r_pkg::ValW-1:0]     val_i,
  output logic [7:0]                          level_o
);

  localparam int unsigned ProdW = 32;
  localparam int unsigned MulW  = h2r_pkg::QuotW + h2r_pkg::RecipW;

  logic             neg_d, neg_q;
  logic             over_d, over_q;
  logic [ProdW-1:0] pre_prod;
  logic [h2r_pkg::QuotW-1:0] w_d, w_q;
  logic [MulW-1:0]  rec_prod;
  logic [7:0]       level_d, level_q;

  // only meaningful for 0 <= val < ClipVal, where 17*val fits in 31 bits
  always_comb begin
    neg_d    = val_i[h2r_pkg::ValW-1];
    over_d   = !neg_d && (val_i >= signed'(h2r_pkg::ValW'(h2r_pkg::ClipVal)));
    pre_prod = ProdW'(unsigned'(val_i)) * ProdW'(h2r_pkg::PreMul);
    w_d      = pre_prod[h2r_pkg::PreShift +: h2r_pkg::QuotW];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_w) begin
      neg_q  <= neg_d;
      over_q <= over_d;
      w_q    <= w_d;
    end
  end

  always_comb begin
    rec_prod = MulW'(w_q) * MulW'(h2r_pkg::RecipM);
    if (neg_q) begin
      level_d = 8'd0;
    end else if (over_q) begin
      level_d = 8'd255;
    end else begin
      level_d = rec_prod[h2r_pkg::RecipShift +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_q) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

`ifndef ASSERT_OFF
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ld_w |=> !(neg_q && over_q))
    else $error("negative and overflow flags both set");
  a_neg_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.ld_q && neg_q) |=> (level_o == 8'd0))
    else $error("negative sum did not give a zero level");
`endif

endmodule
